/* hw/rtl/bcc_pkg.sv */
package bcc_pkg;

    // Width of every coordinate field on the request channel
    localparam int FIELD_W = 16;
    // Width of every weight on the result channel
    localparam int WEIGHT_W = 32;
    // Quotient bits that the divider resolves; anything at 2^33 or above is
    // flagged as overflow before the divider starts
    localparam int Q_BITS = 33;

    typedef struct packed {
        logic signed [FIELD_W-1:0] ax;
        logic signed [FIELD_W-1:0] ay;
        logic signed [FIELD_W-1:0] bx;
        logic signed [FIELD_W-1:0] by_coord;
        logic signed [FIELD_W-1:0] cx;
        logic signed [FIELD_W-1:0] cy;
        logic signed [FIELD_W-1:0] px;
        logic signed [FIELD_W-1:0] py;
    } bcc_req_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] alpha;
        logic signed [WEIGHT_W-1:0] beta;
        logic signed [WEIGHT_W-1:0] gamma;
        logic                       degenerate;
        logic                       saturated;
    } bcc_res_t;

endpackage

/* hw/rtl/barycentric_coordinates_2d.sv */
// Barycentric weights of a query point P in a 2D triangle A, B, C.
// Request channel: req carries the eight coordinates; a request is taken at a
// rising edge with req_valid high and req_stall low. Result channel: res holds
// alpha, beta and gamma in signed fixed point with FRAC_BITS fraction bits,
// plus the degenerate and saturated flags; taken when res_valid is high and
// res_stall low.
// From request to result the pipe runs through one stage for the corner
// differences, one for the products, one for the doubled areas, one for sign
// and magnitude, one for the overflow check, 33 restoring-division stages (one
// quotient bit each, alpha and beta side by side) and the output register.
// Throughput is one request per cycle unless a stalled result holds the pipe.
// Reset clears every valid bit, so the pipe comes up empty with res_valid low.
// When the receiver stalls a valid result, the whole pipe holds and req_stall
// rises in the same cycle; nothing is dropped or repeated. An empty output slot
// does not block: while res_valid is low the pipe keeps advancing.
// A zero triangle area gives zero weights with degenerate set. Weights beyond
// the signed 32-bit range are clamped and flag saturated.
module barycentric_coordinates_2d
    import bcc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  bcc_req_t req,
    output logic     res_valid,
    input  logic     res_stall,
    output bcc_res_t res
);

    // Coordinate width after extension: the field zero-extends when the
    // coordinate is wider than the field
    localparam int CW  = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 1;
    localparam int SH  = CW - COORD_BITS;
    localparam int DFW = CW + 1;
    localparam int PW  = 2 * DFW;
    localparam int AW  = PW + 1;
    localparam int DW  = AW + Q_BITS;
    localparam int NS  = Q_BITS;

    logic en;

    // Advance whenever the output slot is free or is being taken
    assign en        = !res_valid || !res_stall;
    assign req_stall = !en;

    function automatic logic signed [CW-1:0] ext_coord(input logic [FIELD_W-1:0] f);
        logic [CW-1:0] t;
        t = CW'(f) << SH;
        return $signed(t) >>> SH;
    endfunction

    // ---------------- stage 1: corner differences ----------------
    logic signed [CW-1:0]  c_ax, c_ay, c_bx, c_by, c_cx, c_cy, c_px, c_py;
    logic                  s1_valid_reg;
    logic signed [DFW-1:0] bax_reg, cay_reg, cax_reg, bya_reg;
    logic signed [DFW-1:0] bxp_reg, cyp_reg, cxp_reg, byp_reg, ayp_reg, axp_reg;

    always_comb
    begin
        c_ax = ext_coord(req.ax);
        c_ay = ext_coord(req.ay);
        c_bx = ext_coord(req.bx);
        c_by = ext_coord(req.by_coord);
        c_cx = ext_coord(req.cx);
        c_cy = ext_coord(req.cy);
        c_px = ext_coord(req.px);
        c_py = ext_coord(req.py);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bax_reg <= DFW'(c_bx) - DFW'(c_ax);
            cay_reg <= DFW'(c_cy) - DFW'(c_ay);
            cax_reg <= DFW'(c_cx) - DFW'(c_ax);
            bya_reg <= DFW'(c_by) - DFW'(c_ay);
            bxp_reg <= DFW'(c_bx) - DFW'(c_px);
            cyp_reg <= DFW'(c_cy) - DFW'(c_py);
            cxp_reg <= DFW'(c_cx) - DFW'(c_px);
            byp_reg <= DFW'(c_by) - DFW'(c_py);
            ayp_reg <= DFW'(c_ay) - DFW'(c_py);
            axp_reg <= DFW'(c_ax) - DFW'(c_px);
        end
    end

    // ---------------- stage 2: products ----------------
    logic                 s2_valid_reg;
    logic signed [PW-1:0] p_abc1_reg, p_abc2_reg, p_pbc1_reg, p_pbc2_reg;
    logic signed [PW-1:0] p_pca1_reg, p_pca2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_abc1_reg <= bax_reg * cay_reg;
            p_abc2_reg <= cax_reg * bya_reg;
            p_pbc1_reg <= bxp_reg * cyp_reg;
            p_pbc2_reg <= cxp_reg * byp_reg;
            p_pca1_reg <= cxp_reg * ayp_reg;
            p_pca2_reg <= axp_reg * cyp_reg;
        end
    end

    // ---------------- stage 3: doubled areas ----------------
    logic                 s3_valid_reg;
    logic signed [AW-1:0] abc_reg, pbc_reg, pca_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abc_reg <= AW'(p_abc1_reg) - AW'(p_abc2_reg);
            pbc_reg <= AW'(p_pbc1_reg) - AW'(p_pbc2_reg);
            pca_reg <= AW'(p_pca1_reg) - AW'(p_pca2_reg);
        end
    end

    // ---------------- stage 4: sign and magnitude ----------------
    logic          s4_valid_reg;
    logic [AW-1:0] mag_d_reg, mag_a_reg, mag_b_reg;
    logic          neg_a4_reg, neg_b4_reg, degen4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_d_reg  <= abc_reg[AW-1] ? AW'(-abc_reg) : AW'(abc_reg);
            mag_a_reg  <= pbc_reg[AW-1] ? AW'(-pbc_reg) : AW'(pbc_reg);
            mag_b_reg  <= pca_reg[AW-1] ? AW'(-pca_reg) : AW'(pca_reg);
            neg_a4_reg <= pbc_reg[AW-1] ^ abc_reg[AW-1];
            neg_b4_reg <= pca_reg[AW-1] ^ abc_reg[AW-1];
            degen4_reg <= (abc_reg == '0);
        end
    end

    // ---------------- stage 5: overflow check, divider set-up ----------------
    // Index 0 of each array is this stage; index k+1 follows division step k.
    logic          dv_valid_reg [0:NS];
    logic [DW-1:0] rem_a_reg    [0:NS];
    logic [DW-1:0] rem_b_reg    [0:NS];
    logic [NS-1:0] q_a_reg      [0:NS];
    logic [NS-1:0] q_b_reg      [0:NS];
    logic [AW-1:0] den_reg      [0:NS];
    logic          ovf_a_reg    [0:NS];
    logic          ovf_b_reg    [0:NS];
    logic          neg_a_reg    [0:NS];
    logic          neg_b_reg    [0:NS];
    logic          degen_reg    [0:NS];

    logic [DW-1:0] lim;

    // Quotient reaches 2^33 exactly when the dividend reaches den * 2^(33 - F)
    assign lim = DW'(mag_d_reg) << (Q_BITS - FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_a_reg[0] <= DW'(mag_a_reg) << FRAC_BITS;
            rem_b_reg[0] <= DW'(mag_b_reg) << FRAC_BITS;
            q_a_reg[0]   <= '0;
            q_b_reg[0]   <= '0;
            den_reg[0]   <= mag_d_reg;
            ovf_a_reg[0] <= (DW'(mag_a_reg) >= lim);
            ovf_b_reg[0] <= (DW'(mag_b_reg) >= lim);
            neg_a_reg[0] <= neg_a4_reg;
            neg_b_reg[0] <= neg_b4_reg;
            degen_reg[0] <= degen4_reg;
        end
    end

    // ---------------- restoring division, one quotient bit a stage ----------------
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        localparam int BIT = NS - 1 - k;

        logic [DW-1:0] sub;
        logic          take_a, take_b;

        assign sub    = DW'(den_reg[k]) << BIT;
        assign take_a = (rem_a_reg[k] >= sub);
        assign take_b = (rem_b_reg[k] >= sub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k+1] <= take_a ? rem_a_reg[k] - sub : rem_a_reg[k];
                rem_b_reg[k+1] <= take_b ? rem_b_reg[k] - sub : rem_b_reg[k];
                q_a_reg[k+1]   <= q_a_reg[k] | (NS'(take_a) << BIT);
                q_b_reg[k+1]   <= q_b_reg[k] | (NS'(take_b) << BIT);
                den_reg[k+1]   <= den_reg[k];
                ovf_a_reg[k+1] <= ovf_a_reg[k];
                ovf_b_reg[k+1] <= ovf_b_reg[k];
                neg_a_reg[k+1] <= neg_a_reg[k];
                neg_b_reg[k+1] <= neg_b_reg[k];
                degen_reg[k+1] <= degen_reg[k];
            end
        end
    end

    // ---------------- output stage: sign, clamp, gamma ----------------
    localparam logic [NS-1:0] POS_MAX = NS'(33'h0_7FFF_FFFF);
    localparam logic [NS-1:0] NEG_MAX = NS'(33'h0_8000_0000);

    function automatic logic [WEIGHT_W:0] fix_weight(input logic [NS-1:0] q,
                                                     input logic ovf,
                                                     input logic neg);
        logic          sat;
        logic [NS-1:0] v;
        if (neg)
        begin
            sat = ovf || (q > NEG_MAX);
            v   = sat ? ~POS_MAX : NS'(-q);
        end
        else
        begin
            sat = ovf || (q > POS_MAX);
            v   = sat ? POS_MAX : q;
        end
        return {sat, v[WEIGHT_W-1:0]};
    endfunction

    logic [WEIGHT_W:0]         wa, wb;
    logic signed [WEIGHT_W+1:0] g_sum;
    logic                      g_hi, g_lo;
    logic signed [WEIGHT_W-1:0] g_w;
    bcc_res_t                  res_next;
    logic                      res_valid_reg;
    bcc_res_t                  res_reg;

    always_comb
    begin
        wa    = fix_weight(q_a_reg[NS], ovf_a_reg[NS], neg_a_reg[NS]);
        wb    = fix_weight(q_b_reg[NS], ovf_b_reg[NS], neg_b_reg[NS]);
        g_sum = ((WEIGHT_W+2)'(1) << FRAC_BITS)
              - (WEIGHT_W+2)'($signed(wa[WEIGHT_W-1:0]))
              - (WEIGHT_W+2)'($signed(wb[WEIGHT_W-1:0]));
        g_hi  = (g_sum > (WEIGHT_W+2)'(34'sh0_7FFF_FFFF));
        g_lo  = (g_sum < -(WEIGHT_W+2)'(34'sh0_8000_0000));
        if (g_hi)
            g_w = 32'sh7FFF_FFFF;
        else if (g_lo)
            g_w = -32'sh8000_0000;
        else
            g_w = g_sum[WEIGHT_W-1:0];

        res_next.alpha      = wa[WEIGHT_W-1:0];
        res_next.beta       = wb[WEIGHT_W-1:0];
        res_next.gamma      = g_w;
        res_next.degenerate = 1'b0;
        res_next.saturated  = wa[WEIGHT_W] | wb[WEIGHT_W] | g_hi | g_lo;
        // Drop the weights of a flat triangle
        if (degen_reg[NS])
        begin
            res_next.alpha      = '0;
            res_next.beta       = '0;
            res_next.gamma      = '0;
            res_next.degenerate = 1'b1;
            res_next.saturated  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= dv_valid_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---------------- assertions ----------------
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
        else $error("request stalled with the output slot free");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.degenerate) |->
            (res.alpha == '0 && res.beta == '0 && res.gamma == '0 && !res.saturated))
        else $error("flat triangle gave non-zero weights");

    a_gamma_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.degenerate && !res.saturated) |->
            ((WEIGHT_W+2)'(res.alpha) + (WEIGHT_W+2)'(res.beta) + (WEIGHT_W+2)'(res.gamma)
                == ((WEIGHT_W+2)'(1) << FRAC_BITS)))
        else $error("weights do not sum to one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (req_stall && dv_valid_reg[NS]) |=> (dv_valid_reg[NS] && $stable(q_a_reg[NS])))
        else $error("divider output moved while the pipe was held");

endmodule

/* test/tb_barycentric_coordinates_2d.sv */
`timescale 1ns / 100ps

module tb_barycentric_coordinates_2d
    import bcc_pkg::*;
;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = 39;
    localparam longint CYCLE_LIMIT = 400000;

    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;
    localparam logic [63:0] Q_CAP = 64'h1_0000_0000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    bcc_req_t req;
    logic     res_valid;
    logic     res_stall;
    bcc_res_t res;

    // Weights still owed by the block, oldest first
    bcc_res_t weights_due[$];
    int       error_count;
    longint   cycle_count;
    // Receiver behaviour: 0 random stalls, 1 never stall, 2 long hold-off
    int       sink_mode;
    int       hold_len;
    // Sender gap behaviour: 0 bursts with gaps, 1 back to back
    int       gap_mode;

    barycentric_coordinates_2d #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    always #5 clk = ~clk;

    // Read a field as a COORD_BITS-wide signed value
    function automatic longint coord_val(logic [FIELD_W-1:0] v);
        logic [63:0] m;
        m = {48'd0, v} & ((64'd1 << COORD_BITS) - 64'd1);
        if (m[COORD_BITS-1])
            return longint'(m) - (longint'(1) << COORD_BITS);
        return longint'(m);
    endfunction

    function automatic longint twice_area(longint ux, longint uy, longint vx, longint vy,
                                          longint wx, longint wy);
        return (vx - ux) * (wy - uy) - (wx - ux) * (vy - uy);
    endfunction

    // Fixed-point quotient, truncated toward zero, clamped to 32 bits
    function automatic longint fixed_quotient(longint num, longint den, inout logic sat);
        logic [63:0] n, d, q, r;
        logic        neg;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        neg = (num < 0) != (den < 0);
        if (q > Q_CAP)
            q = Q_CAP;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q[0] = 1'b1;
            end
            if (q > Q_CAP)
                q = Q_CAP;
        end
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1'b1;
                return W_MIN;
            end
            return -longint'(q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return W_MAX;
        end
        return longint'(q);
    endfunction

    function automatic bcc_res_t predict_weights(bcc_req_t r);
        longint   ax, ay, bx, by, cx, cy, px, py, abc, pbc, pca, al, be, ga;
        bcc_res_t o;
        logic     sat;
        ax = coord_val(r.ax);  ay = coord_val(r.ay);
        bx = coord_val(r.bx);  by = coord_val(r.by_coord);
        cx = coord_val(r.cx);  cy = coord_val(r.cy);
        px = coord_val(r.px);  py = coord_val(r.py);
        abc = twice_area(ax, ay, bx, by, cx, cy);
        pbc = twice_area(px, py, bx, by, cx, cy);
        pca = twice_area(px, py, cx, cy, ax, ay);
        sat = 1'b0;
        o = '0;
        if (abc == 0)
            o.degenerate = 1'b1;
        else
        begin
            al = fixed_quotient(pbc, abc, sat);
            be = fixed_quotient(pca, abc, sat);
            ga = (longint'(1) << FRAC_BITS) - (al + be);
            if (ga > W_MAX)
            begin
                ga = W_MAX;
                sat = 1'b1;
            end
            else if (ga < W_MIN)
            begin
                ga = W_MIN;
                sat = 1'b1;
            end
            o.alpha = al[31:0];
            o.beta  = be[31:0];
            o.gamma = ga[31:0];
        end
        o.saturated = sat;
        return o;
    endfunction

    // Offer one request, hold it until taken, then drop valid unless a burst goes on
    task automatic send_request(bcc_req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        weights_due.push_back(predict_weights(r));
        @(negedge clk);
        if (gap_mode == 0 && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (weights_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2)
            @(negedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] rand_coord(int span);
        case ($urandom_range(0, 3))
            0: return FIELD_W'($urandom);
            1: return FIELD_W'(16'h7FFF - $urandom_range(0, 3));
            2: return FIELD_W'(16'h8000 + $urandom_range(0, 3));
            default: return FIELD_W'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    function automatic bcc_req_t rand_request();
        bcc_req_t r;
        int       span;
        span = $urandom_range(0, 1) ? 40 : 32767;
        r.ax = rand_coord(span); r.ay = rand_coord(span);
        r.bx = rand_coord(span); r.by_coord = rand_coord(span);
        r.cx = rand_coord(span); r.cy = rand_coord(span);
        r.px = rand_coord(span); r.py = rand_coord(span);
        // Now and then make the triangle flat or put P on a corner
        case ($urandom_range(0, 9))
            0: begin r.cx = r.bx; r.cy = r.by_coord; end
            1: begin r.px = r.ax; r.py = r.ay; end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bcc_req_t make_request(int ax, int ay, int bx, int by,
                                              int cx, int cy, int px, int py);
        bcc_req_t r;
        r.ax = FIELD_W'(ax); r.ay = FIELD_W'(ay);
        r.bx = FIELD_W'(bx); r.by_coord = FIELD_W'(by);
        r.cx = FIELD_W'(cx); r.cy = FIELD_W'(cy);
        r.px = FIELD_W'(px); r.py = FIELD_W'(py);
        return r;
    endfunction

    // Corners, centroid, edges, flat triangles, extremes and saturation
    task automatic test_directed();
        gap_mode = 1;
        send_request(make_request(0, 0, 4, 0, 0, 4, 0, 0));
        send_request(make_request(0, 0, 4, 0, 0, 4, 4, 0));
        send_request(make_request(0, 0, 4, 0, 0, 4, 0, 4));
        send_request(make_request(0, 0, 3, 0, 0, 3, 1, 1));
        send_request(make_request(0, 0, 4, 0, 0, 4, 2, 2));
        send_request(make_request(0, 0, 4, 0, 0, 4, -5, 9));
        send_request(make_request(0, 0, 0, 4, 4, 0, 1, 1));
        send_request(make_request(0, 0, 1, 1, 2, 2, 5, 3));
        send_request(make_request(7, 7, 7, 7, 7, 7, 7, 7));
        send_request(make_request(-32768, -32768, 32767, -32768, -32768, 32767,
                                  0, 0));
        send_request(make_request(-32768, -32768, 32767, -32768, -32768, 32767,
                                  32767, 32767));
        // Unit area with P far away drives the weights past 32 bits
        send_request(make_request(0, 0, 1, 0, 0, 1, 32767, 32767));
        send_request(make_request(0, 0, 1, 0, 0, 1, -32768, -32768));
        send_request(make_request(0, 0, 1, 0, 0, 1, -32768, 32767));
        send_request(make_request(0, 0, 1, 0, 0, 1, 32767, -32768));
        send_request(make_request(32767, 32767, -32768, -32768, 32767, -32768,
                                  -32768, 32767));
        send_request(make_request(0, 0, 3, 0, 0, 7, 1, 2));
        send_request(make_request(-1, -1, -1, 0, 0, -1, 0, 0));
        wait_drained();
    endtask

    task automatic test_random(int count);
        gap_mode = 0;
        sink_mode = 0;
        for (int i = 0; i < count; i++)
            send_request(rand_request());
    endtask

    task automatic test_back_to_back(int count);
        gap_mode = 1;
        sink_mode = 1;
        for (int i = 0; i < count; i++)
            send_request(rand_request());
        sink_mode = 0;
    endtask

    // Hold the receiver off so the pipe fills and stalls the request side
    task automatic test_long_hold(int count);
        gap_mode = 1;
        hold_len = 150;
        sink_mode = 2;
        for (int i = 0; i < count; i++)
            send_request(rand_request());
    endtask

    // Receiver stall pattern
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_mode == 2)
            begin
                res_stall <= 1'b1;
                repeat (hold_len)
                    @(negedge clk);
                res_stall <= 1'b0;
                sink_mode = 0;
            end
            else if (sink_mode == 1)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Check every result taken against the oldest prediction
    always @(posedge clk)
    begin
        bcc_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (weights_due.size() == 0)
            begin
                $display("%0t: result with none due: %h", $time, res);
                error_count++;
            end
            else
            begin
                want = weights_due.pop_front();
                if (res.alpha !== want.alpha)
                begin
                    $display("%0t: alpha expected %h actual %h", $time, want.alpha, res.alpha);
                    error_count++;
                end
                if (res.beta !== want.beta)
                begin
                    $display("%0t: beta expected %h actual %h", $time, want.beta, res.beta);
                    error_count++;
                end
                if (res.gamma !== want.gamma)
                begin
                    $display("%0t: gamma expected %h actual %h", $time, want.gamma, res.gamma);
                    error_count++;
                end
                if (res.degenerate !== want.degenerate)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             want.degenerate, res.degenerate);
                    error_count++;
                end
                if (res.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, res.saturated);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_barycentric_coordinates_2d: errors");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        error_count = 0;
        cycle_count = 0;
        sink_mode = 0;
        gap_mode = 0;
        hold_len = 0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(500);
        test_long_hold(120);
        wait_drained();
        test_back_to_back(200);
        test_random(500);
        wait_drained();
        if (error_count == 0 && weights_due.size() == 0)
            $display("tb_barycentric_coordinates_2d: clean");
        else
            $display("tb_barycentric_coordinates_2d: errors");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bcc_pkg.sv
hw/rtl/barycentric_coordinates_2d.sv
test/tb_barycentric_coordinates_2d.sv
